FILE: rtl/ubxsf_pkg.sv
package ubxsf_pkg;

  localparam logic [7:0]  SYNC1_BYTE = 8'hB5;
  localparam logic [7:0]  SYNC2_BYTE = 8'h62;
  localparam logic [7:0]  NAV_CLASS  = 8'h02;
  localparam logic [7:0]  NAV_IDENT  = 8'h13;
  localparam logic [7:0]  GNSS_ID    = 8'd5;
  localparam logic [7:0]  MIN_WORDS  = 8'd8;
  localparam logic [15:0] MIN_LEN    = 16'd8;
  localparam logic [10:0] WORD_BASE  = 11'd8;
  localparam logic [7:0]  LAST_MASK  = 8'hC0;

  localparam int unsigned HEAD_DEPTH = 40;
  localparam int unsigned HEAD_AW    = $clog2(HEAD_DEPTH);
  localparam int unsigned NAV_BYTES  = 32;
  localparam int unsigned NAV_KW     = $clog2(NAV_BYTES);

  // payload offsets of captured header fields
  localparam logic [15:0] OFS_GNSS  = 16'd0;
  localparam logic [15:0] OFS_SAT   = 16'd1;
  localparam logic [15:0] OFS_SIG   = 16'd2;
  localparam logic [15:0] OFS_WORDS = 16'd4;
  localparam logic [HEAD_AW-1:0] WORD_OFS = HEAD_AW'(8);

  typedef enum logic [3:0] {
    PH_SYNC1,
    PH_SYNC2,
    PH_CLASS,
    PH_IDENT,
    PH_LEN_LO,
    PH_LEN_HI,
    PH_PAYLOAD,
    PH_CK_A,
    PH_CK_B,
    PH_EMIT_RD,
    PH_EMIT_OUT
  } phase_e;

  typedef struct packed {
    logic ld_class;
    logic ld_ident;
    logic ld_len_lo;
    logic ld_len_hi;
    logic pay_wr;
    logic emit_start;
    logic rd_en;
    logic k_inc;
  } cmd_t;

  typedef struct packed {
    logic sync1_hit;
    logic sync2_hit;
    logic len_ok;
    logic pay_done;
    logic ck_a_ok;
    logic ck_b_ok;
    logic qualify;
    logic k_last;
  } sts_t;

endpackage

FILE: rtl/ubxsf_if.sv
interface ubxsf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ubxsf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] nav_byte;
  logic [7:0] sat_id;
  logic       last_byte;

  modport source (output valid, output nav_byte, output sat_id, output last_byte, input ready);
  modport sink   (input valid, input nav_byte, input sat_id, input last_byte, output ready);
endinterface

FILE: rtl/ubx_sfrbx_subframe_extractor.sv
// Frames a binary receiver byte stream (B5 62, class, id, length, payload,
// two Fletcher-8 check bytes) and, for a good class 02 id 13 frame of gnss 5,
// signal 0 or 1 with at least eight words, sends 32 bytes holding the first
// 250 subframe bits MSB first, the last byte cut to its top two bits. While
// framing, one rx request is taken every cycle. After the check byte of a
// qualifying frame, input is held off for the 32-byte run: each byte is one
// read of the 40-byte payload RAM, then an output request held until taken.
module ubx_sfrbx_subframe_extractor #(
  parameter int unsigned MAX_PAYLOAD = 1024
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  ubxsf_in_if.sink     rx_req_i,
  ubxsf_out_if.source  nav_req_o
);

  ubxsf_pkg::cmd_t cmd;
  ubxsf_pkg::sts_t sts;

  ubxsf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (rx_req_i.valid),
    .in_ready_o  (rx_req_i.ready),
    .out_valid_o (nav_req_o.valid),
    .out_ready_i (nav_req_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ubxsf_dpath #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_byte_i   (rx_req_i.rx_byte),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .nav_byte_o  (nav_req_o.nav_byte),
    .sat_id_o    (nav_req_o.sat_id),
    .last_byte_o (nav_req_o.last_byte)
  );

endmodule

FILE: rtl/ubxsf_ram.sv
module ubxsf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 40
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/ubxsf_ctrl.sv
module ubxsf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  ubxsf_pkg::sts_t   sts_i,
  output ubxsf_pkg::cmd_t   cmd_o
);

  ubxsf_pkg::phase_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ubxsf_pkg::PH_SYNC1;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ubxsf_pkg::PH_SYNC1: begin
        in_ready_o = 1'b1;
        if (in_valid_i && sts_i.sync1_hit) state_d = ubxsf_pkg::PH_SYNC2;
      end
      ubxsf_pkg::PH_SYNC2: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = sts_i.sync2_hit ? ubxsf_pkg::PH_CLASS : ubxsf_pkg::PH_SYNC1;
        end
      end
      ubxsf_pkg::PH_CLASS: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.ld_class = 1'b1;
          state_d        = ubxsf_pkg::PH_IDENT;
        end
      end
      ubxsf_pkg::PH_IDENT: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.ld_ident = 1'b1;
          state_d        = ubxsf_pkg::PH_LEN_LO;
        end
      end
      ubxsf_pkg::PH_LEN_LO: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.ld_len_lo = 1'b1;
          state_d         = ubxsf_pkg::PH_LEN_HI;
        end
      end
      ubxsf_pkg::PH_LEN_HI: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.ld_len_hi = 1'b1;
          state_d = sts_i.len_ok ? ubxsf_pkg::PH_PAYLOAD : ubxsf_pkg::PH_SYNC1;
        end
      end
      ubxsf_pkg::PH_PAYLOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.pay_wr = 1'b1;
          if (sts_i.pay_done) state_d = ubxsf_pkg::PH_CK_A;
        end
      end
      ubxsf_pkg::PH_CK_A: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = sts_i.ck_a_ok ? ubxsf_pkg::PH_CK_B : ubxsf_pkg::PH_SYNC1;
        end
      end
      ubxsf_pkg::PH_CK_B: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (sts_i.ck_b_ok && sts_i.qualify) begin
            cmd_o.emit_start = 1'b1;
            state_d          = ubxsf_pkg::PH_EMIT_RD;
          end else begin
            state_d = ubxsf_pkg::PH_SYNC1;
          end
        end
      end
      ubxsf_pkg::PH_EMIT_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = ubxsf_pkg::PH_EMIT_OUT;
      end
      ubxsf_pkg::PH_EMIT_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (sts_i.k_last) begin
            state_d = ubxsf_pkg::PH_SYNC1;
          end else begin
            cmd_o.k_inc = 1'b1;
            state_d     = ubxsf_pkg::PH_EMIT_RD;
          end
        end
      end
      default: state_d = ubxsf_pkg::PH_SYNC1;
    endcase
  end

endmodule

FILE: rtl/ubxsf_dpath.sv
module ubxsf_dpath #(
  parameter int unsigned MAX_PAYLOAD = 1024
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [7:0]      rx_byte_i,
  input  ubxsf_pkg::cmd_t cmd_i,
  output ubxsf_pkg::sts_t sts_o,
  output logic [7:0]      nav_byte_o,
  output logic [7:0]      sat_id_o,
  output logic            last_byte_o
);

  logic [7:0]  class_q, ident_q;
  logic [15:0] len_q, count_q;
  logic [7:0]  sum_a_q, sum_b_q;
  logic [7:0]  gnss_q, sat_q, sig_q, words_q;
  logic [ubxsf_pkg::NAV_KW-1:0] k_q;

  logic [7:0]  sum_a_add, sum_b_add;
  logic [15:0] len_new;
  logic [10:0] need_len;
  logic [ubxsf_pkg::HEAD_AW-1:0] raddr;
  logic [7:0]  rdata;
  logic        head_we;

  assign sum_a_add = sum_a_q + rx_byte_i;
  assign sum_b_add = sum_b_q + sum_a_add;
  assign len_new   = {rx_byte_i, len_q[7:0]};
  assign head_we   = cmd_i.pay_wr && (count_q < 16'(ubxsf_pkg::HEAD_DEPTH));

  // word w of the subframe, byte j counted from the top: payload 8 + 4w + (3 - j)
  assign raddr = ubxsf_pkg::WORD_OFS
               + ubxsf_pkg::HEAD_AW'({k_q[ubxsf_pkg::NAV_KW-1:2], ~k_q[1:0]});

  assign need_len = ubxsf_pkg::WORD_BASE + {1'b0, words_q, 2'b00};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      class_q <= '0;
      ident_q <= '0;
      len_q   <= '0;
      count_q <= '0;
      sum_a_q <= '0;
      sum_b_q <= '0;
      k_q     <= '0;
    end else begin
      if (cmd_i.ld_class) begin
        class_q <= rx_byte_i;
        sum_a_q <= rx_byte_i;
        sum_b_q <= rx_byte_i;
      end
      if (cmd_i.ld_ident) begin
        ident_q <= rx_byte_i;
      end
      if (cmd_i.ld_len_lo) begin
        len_q <= {8'd0, rx_byte_i};
      end
      if (cmd_i.ld_len_hi) begin
        len_q   <= len_new;
        count_q <= '0;
      end
      if (cmd_i.pay_wr) begin
        count_q <= count_q + 16'd1;
      end
      if (cmd_i.ld_ident || cmd_i.ld_len_lo || cmd_i.ld_len_hi || cmd_i.pay_wr) begin
        sum_a_q <= sum_a_add;
        sum_b_q <= sum_b_add;
      end
      if (cmd_i.emit_start) begin
        k_q <= '0;
      end else if (cmd_i.k_inc) begin
        k_q <= k_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pay_wr) begin
      if (count_q == ubxsf_pkg::OFS_GNSS)  gnss_q  <= rx_byte_i;
      if (count_q == ubxsf_pkg::OFS_SAT)   sat_q   <= rx_byte_i;
      if (count_q == ubxsf_pkg::OFS_SIG)   sig_q   <= rx_byte_i;
      if (count_q == ubxsf_pkg::OFS_WORDS) words_q <= rx_byte_i;
    end
  end

  ubxsf_ram #(
    .WIDTH (8),
    .DEPTH (ubxsf_pkg::HEAD_DEPTH)
  ) u_head (
    .clk_i   (clk_i),
    .we_i    (head_we),
    .waddr_i (count_q[ubxsf_pkg::HEAD_AW-1:0]),
    .wdata_i (rx_byte_i),
    .re_i    (cmd_i.rd_en),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    sts_o.sync1_hit = (rx_byte_i == ubxsf_pkg::SYNC1_BYTE);
    sts_o.sync2_hit = (rx_byte_i == ubxsf_pkg::SYNC2_BYTE);
    sts_o.len_ok    = (len_new != 16'd0) && (32'(len_new) <= 32'(MAX_PAYLOAD));
    sts_o.pay_done  = ({1'b0, count_q} + 17'd1) >= {1'b0, len_q};
    sts_o.ck_a_ok   = (rx_byte_i == sum_a_q);
    sts_o.ck_b_ok   = (rx_byte_i == sum_b_q);
    sts_o.qualify   = (class_q == ubxsf_pkg::NAV_CLASS)
                   && (ident_q == ubxsf_pkg::NAV_IDENT)
                   && (len_q >= ubxsf_pkg::MIN_LEN)
                   && (gnss_q == ubxsf_pkg::GNSS_ID)
                   && ((sig_q == 8'd0) || (sig_q == 8'd1))
                   && (words_q >= ubxsf_pkg::MIN_WORDS)
                   && (len_q >= {5'd0, need_len});
    sts_o.k_last    = (k_q == ubxsf_pkg::NAV_KW'(ubxsf_pkg::NAV_BYTES - 1));
  end

  assign last_byte_o = sts_o.k_last;
  assign nav_byte_o  = sts_o.k_last ? (rdata & ubxsf_pkg::LAST_MASK) : rdata;
  assign sat_id_o    = sat_q;

endmodule

FILE: rtl/ubxsf_checker.sv
module ubxsf_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] nav_byte_i,
  input logic [7:0] sat_id_i,
  input logic       last_byte_i
);

  // stalled output request holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(nav_byte_i)
      && $stable(sat_id_i) && $stable(last_byte_i))
    else $error("output request changed while stalled");

  // input is not ready while an output request is up
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_i && out_valid_i))
    else $error("input ready during output run");

  // final byte is masked to its top two bits
  a_last_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && last_byte_i |-> nav_byte_i[5:0] == 6'd0)
    else $error("final byte not masked");

  // run ends after its final byte
  a_run_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && last_byte_i |=> !out_valid_i && in_ready_i)
    else $error("run did not end after final byte");

  // satellite id constant within a run
  a_sat_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !last_byte_i |=> $stable(sat_id_i))
    else $error("satellite id changed within run");

endmodule

bind ubx_sfrbx_subframe_extractor ubxsf_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (rx_req_i.ready),
  .out_valid_i (nav_req_o.valid),
  .out_ready_i (nav_req_o.ready),
  .nav_byte_i  (nav_req_o.nav_byte),
  .sat_id_i    (nav_req_o.sat_id),
  .last_byte_i (nav_req_o.last_byte)
);
